>>> hdl/tdac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day alarm clock package
// Shared constants, register indexes and the result word type.
// ----------------------------------------------------------------------------
package tdac_pkg;

  // Prescaler: fast ticks per second and the counter width that holds them.
  localparam int unsigned TICKS_PER_SECOND = 100;
  localparam int unsigned PRESC_W          = $clog2(TICKS_PER_SECOND);

  // Field widths.
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned NUM_ALARMS = 3;
  localparam int unsigned ALARM_W    = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DAYS_W     = 7;

  // Time limits.
  localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
  localparam logic [WDAY_W-1:0] WDAY_MIN = WDAY_W'(1);
  localparam logic [WDAY_W-1:0] WDAY_MAX = WDAY_W'(7);

  // Alarm word packing.
  localparam int unsigned AL_EN_BIT   = 19;
  localparam int unsigned AL_PWR_BIT  = 18;
  localparam int unsigned AL_DAYS_LSB = 11;
  localparam int unsigned AL_HOUR_LSB = 6;
  localparam int unsigned AL_MIN_LSB  = 0;

  // Request kinds.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM2 = CFG_IDX_W'(2);

  // One result word.
  typedef struct packed {
    logic [SEC_W-1:0]      second;
    logic [MIN_W-1:0]      minute;
    logic [HOUR_W-1:0]     hour;
    logic [WDAY_W-1:0]     weekday;
    logic [NUM_ALARMS-1:0] fired;
    logic                  power;
  } result_t;

endpackage

>>> hdl/time_of_day_alarm_clock_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-of-day alarm clock with three weekly alarms
// Counts prescaler ticks into seconds, minutes, hours and weekday, matches
// three alarms at the top of each minute and tracks the device power state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per fast tick or
//   per time-set request. Output channel (out_valid_o / out_stall_i) returns
//   one word per input word: the time after it, the alarms that fired on it
//   and the resulting power state.
//   An accepted word's result is registered in the output register, or in the
//   skid register while the output register is full and stalled. The block
//   takes one word per cycle while in_stall_o is low; the time update and the
//   three alarm compares are a single pass of logic on the state registers.
//   A two-entry output stage (output register plus skid register) lets the
//   block take one more word while a result waits. in_stall_o is high while
//   the skid register holds a word, which happens only after the receiver has
//   stalled with the output register full; it drops at the edge at which the
//   receiver takes the output word.
//   Reset clears the time to Monday 00:00:00, the prescaler to zero, the
//   power to off and all alarm words to zero, and empties the output stage.
//   Alarm words are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, by
//   the user only while the block is idle (unenforced); index 3 is ignored.
// ----------------------------------------------------------------------------
module time_of_day_alarm_clock_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration
  input  logic                           cfg_we_i,
  input  logic [tdac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tdac_pkg::ALARM_W-1:0]   cfg_wdata_i,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [tdac_pkg::SEC_W-1:0]     set_second_i,
  input  logic [tdac_pkg::MIN_W-1:0]     set_minute_i,
  input  logic [tdac_pkg::HOUR_W-1:0]    set_hour_i,
  input  logic [tdac_pkg::WDAY_W-1:0]    set_weekday_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tdac_pkg::SEC_W-1:0]     now_second_o,
  output logic [tdac_pkg::MIN_W-1:0]     now_minute_o,
  output logic [tdac_pkg::HOUR_W-1:0]    now_hour_o,
  output logic [tdac_pkg::WDAY_W-1:0]    now_weekday_o,
  output logic [tdac_pkg::NUM_ALARMS-1:0] fired_mask_o,
  output logic                           power_state_o
);
  import tdac_pkg::*;

  // State registers.
  logic [PRESC_W-1:0]  presc_q, presc_d;
  logic [SEC_W-1:0]    sec_q, sec_d;
  logic [MIN_W-1:0]    min_q, min_d;
  logic [HOUR_W-1:0]   hour_q, hour_d;
  logic [WDAY_W-1:0]   wday_q, wday_d;
  logic                power_q, power_d;
  logic [ALARM_W-1:0]  alarm_q [NUM_ALARMS];

  // Output stage.
  result_t             out_q, skid_q, res_d;
  logic                out_valid_q, skid_valid_q;

  logic                in_acc;
  logic                out_ready;
  logic [NUM_ALARMS-1:0] fired;
  logic [DAYS_W-1:0]   al_days;
  logic [HOUR_W-1:0]   al_hour;
  logic [MIN_W-1:0]    al_min;
  logic                day_ok;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_ready  = !out_valid_q || !out_stall_i;

  // Alarm word registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        alarm_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALARM0: alarm_q[0] <= cfg_wdata_i;
        CFG_ALARM1: alarm_q[1] <= cfg_wdata_i;
        CFG_ALARM2: alarm_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next time, alarm match and power for the word being accepted.
  always_comb begin
    presc_d = presc_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    wday_d  = wday_q;
    power_d = power_q;
    fired   = '0;
    al_days = '0;
    al_hour = '0;
    al_min  = '0;
    day_ok  = 1'b0;
    if (req_type_i == REQ_SET) begin
      // Load the requested time, clipped to the legal ranges.
      sec_d  = (set_second_i > SEC_MAX) ? SEC_MAX : set_second_i;
      min_d  = (set_minute_i > MIN_MAX) ? MIN_MAX : set_minute_i;
      hour_d = (set_hour_i > HOUR_MAX) ? HOUR_MAX : set_hour_i;
      wday_d = (set_weekday_i == '0) ? WDAY_MIN : set_weekday_i;
    end else if (presc_q == PRESC_W'(TICKS_PER_SECOND - 1)) begin
      // A full second has passed: step the time.
      presc_d = '0;
      if (sec_q == SEC_MAX) begin
        sec_d = '0;
        if (min_q == MIN_MAX) begin
          min_d = '0;
          if (hour_q == HOUR_MAX) begin
            hour_d = '0;
            wday_d = (wday_q == WDAY_MAX) ? WDAY_MIN : wday_q + WDAY_W'(1);
          end else begin
            hour_d = hour_q + HOUR_W'(1);
          end
        end else begin
          min_d = min_q + MIN_W'(1);
        end
        // Alarms are matched at the top of the minute; the highest fired one
        // sets the power.
        for (int i = 0; i < NUM_ALARMS; i++) begin
          al_days = alarm_q[i][AL_DAYS_LSB +: DAYS_W];
          al_hour = alarm_q[i][AL_HOUR_LSB +: HOUR_W];
          al_min  = alarm_q[i][AL_MIN_LSB +: MIN_W];
          day_ok  = (al_days == '0) || al_days[wday_d - WDAY_W'(1)];
          if (alarm_q[i][AL_EN_BIT] && day_ok && al_hour == hour_d && al_min == min_d) begin
            fired[i] = 1'b1;
            power_d  = alarm_q[i][AL_PWR_BIT];
          end
        end
      end else begin
        sec_d = sec_q + SEC_W'(1);
      end
    end else begin
      presc_d = presc_q + PRESC_W'(1);
    end
    res_d = '{second: sec_d, minute: min_d, hour: hour_d, weekday: wday_d,
              fired: fired, power: power_d};
  end

  // Time state, updated on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      sec_q   <= '0;
      min_q   <= '0;
      hour_q  <= '0;
      wday_q  <= WDAY_MIN;
      power_q <= 1'b0;
    end else if (in_acc) begin
      presc_q <= presc_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      wday_q  <= wday_d;
      power_q <= power_d;
    end
  end

  // Output stage control: the skid entry drains first, then new words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_ready) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_ready) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign now_second_o  = out_q.second;
  assign now_minute_o  = out_q.minute;
  assign now_hour_o    = out_q.hour;
  assign now_weekday_o = out_q.weekday;
  assign fired_mask_o  = out_q.fired;
  assign power_state_o = out_q.power;

  // The skid entry is only ever filled behind a waiting output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  // Alarms only fire on a result at second zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && fired_mask_o != '0) |-> now_second_o == '0)
    else $error("alarm fired away from the top of the minute");

  // The held time stays within its legal ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   sec_q <= SEC_MAX && min_q <= MIN_MAX && hour_q <= HOUR_MAX &&
                   wday_q != '0)
    else $error("time state out of range");

  // A set request never reports a fired alarm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_acc && out_ready && !skid_valid_q && req_type_i == REQ_SET)
                   |=> out_q.fired == '0)
    else $error("alarm reported on a time-set word");

endmodule
